### hdl/sos_pkg.sv
// Shared types, constants and arithmetic helpers for the shell-order strip index generator.
// Used by sos_front, sos_queue, sos_back and shell_order_strip_index_gen; depends on nothing.
`timescale 1ns / 1ps

package sos_pkg;

  // Bits of the shell number, the integer square root of a 16-bit pixel index.
  localparam int ROOT_BITS = 8;

  // Entries of the queue between the front and the back.
  localparam int QDEPTH = 16;

  // Partial root and the square of that partial root.
  typedef struct packed {
    logic [ROOT_BITS-1:0] res;
    logic [15:0]          sq;
  } root_t;

  // A classified pixel: grid position, direction and the two extra-vertex flags.
  typedef struct packed {
    logic [7:0] i;
    logic [7:0] j;
    logic [1:0] dir;
    logic       pre;
    logic       post;
  } item_t;

  // Corner offsets per direction; bit s of an entry is the offset of strip slot s.
  // Slot 0 is the leading extra vertex, slots 1 and 2 are always sent, slot 3 is
  // the trailing extra vertex.
  localparam logic [3:0] CORNER_DI [4] = '{4'b0011, 4'b1100, 4'b1010, 4'b1010};
  localparam logic [3:0] CORNER_DJ [4] = '{4'b1010, 4'b1010, 4'b0011, 4'b1100};

  // One bit of the digit-by-digit square root. The square of the candidate is
  // built from the running square by adds only: (res + 2^b)^2 = res^2 + res*2^(b+1) + 4^b.
  function automatic root_t sos_root_step(input logic [15:0] n, input root_t cur,
                                          input logic [2:0] b);
    logic [ROOT_BITS-1:0] cand;
    logic [16:0]          cand_sq;
    logic [3:0]           sh_res;
    logic [3:0]           sh_one;
    root_t                nxt;
    cand    = cur.res | (ROOT_BITS'(1) << b);
    sh_res  = 4'(b) + 4'd1;
    sh_one  = {b, 1'b0};
    cand_sq = {1'b0, cur.sq} + ({9'd0, cur.res} << sh_res) + (17'd1 << sh_one);
    nxt     = cur;
    if (cand_sq <= {1'b0, n}) begin
      nxt.res = cand;
      nxt.sq  = cand_sq[15:0];
    end
    return nxt;
  endfunction

  // Maps a grid position back to its shell-order vertex number.
  function automatic logic [16:0] sos_vertex_number(input logic [8:0] vi, input logic [8:0] vj);
    logic [8:0]  m;
    logic [9:0]  a;
    logic [17:0] sq;
    if (vi < vj) begin
      m = vj;
      a = vj[0] ? {1'b0, vi} : ({vj, 1'b0} - {1'b0, vi});
    end else begin
      m = vi;
      a = vi[0] ? ({vi, 1'b0} - {1'b0, vj}) : {1'b0, vj};
    end
    sq = 18'(m) * 18'(m);
    return 17'(sq + 18'(a));
  endfunction

endpackage

### hdl/sos_front.sv
// Front end: accepts pixel indices, finds the shell by a pipelined square root and
// classifies the pixel into grid position, direction and extra-vertex flags. Uses sos_pkg.
`timescale 1ns / 1ps

module sos_front import sos_pkg::*; #(
  parameter int MAX_DIM = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [15:0] in_pixel_index,
  output logic        in_full,
  input  logic        release_i,
  output logic        q_push,
  output item_t       q_item
);

  localparam logic [24:0] GRID_LIMIT = 25'(MAX_DIM * MAX_DIM);
  localparam int          CW         = $clog2(QDEPTH + 1);

  logic [CW-1:0] credit_r, credit_nxt;
  logic          accept;
  logic          enter;

  logic          stg_vld_r  [ROOT_BITS];
  logic [15:0]   stg_n_r    [ROOT_BITS];
  root_t         stg_root_r [ROOT_BITS];
  root_t         stg_root_nxt [ROOT_BITS];

  // Every pixel in flight holds a credit, so the queue can never overflow.
  assign in_full = (credit_r == CW'(QDEPTH));
  assign accept  = in_push && !in_full;
  assign enter   = accept && ({9'd0, in_pixel_index} < GRID_LIMIT);

  always_comb begin
    credit_nxt = credit_r + CW'(enter) - CW'(release_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
    if (k == 0) begin : g_first
      assign stg_root_nxt[k] = sos_root_step(in_pixel_index, '0, 3'(ROOT_BITS - 1));
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_vld_r[k] <= 1'b0;
        end else begin
          stg_vld_r[k] <= enter;
        end
      end
      always_ff @(posedge clk) begin
        stg_n_r[k]    <= in_pixel_index;
        stg_root_r[k] <= stg_root_nxt[k];
      end
    end else begin : g_next
      assign stg_root_nxt[k] = sos_root_step(stg_n_r[k-1], stg_root_r[k-1],
                                             3'(ROOT_BITS - 1 - k));
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_vld_r[k] <= 1'b0;
        end else begin
          stg_vld_r[k] <= stg_vld_r[k-1];
        end
      end
      always_ff @(posedge clk) begin
        stg_n_r[k]    <= stg_n_r[k-1];
        stg_root_r[k] <= stg_root_nxt[k];
      end
    end
  end

  // Classification of the finished root: remainder, direction, position, flags.
  always_comb begin
    logic [7:0] l;
    logic [8:0] r;
    logic       ge;
    logic [7:0] pi;
    logic [7:0] pj;
    l  = stg_root_r[ROOT_BITS-1].res;
    r  = 9'(stg_n_r[ROOT_BITS-1] - stg_root_r[ROOT_BITS-1].sq);
    ge = (r >= {1'b0, l});
    if (!ge) begin
      pi = r[7:0];
      pj = l;
    end else begin
      pi = l;
      pj = 8'({l, 1'b0} - r);
    end
    if (!l[0]) begin
      q_item.i = pj;
      q_item.j = pi;
    end else begin
      q_item.i = pi;
      q_item.j = pj;
    end
    q_item.dir  = {l[0], 1'b0} + 2'(ge) + 2'd3;
    q_item.pre  = (r == {1'b0, l});
    q_item.post = (r == {l, 1'b0});
  end

  assign q_push = stg_vld_r[ROOT_BITS-1];

endmodule

### hdl/sos_queue.sv
// Short first-in first-out queue of classified pixels between the front and the back.
// Uses item_t and QDEPTH from sos_pkg.
`timescale 1ns / 1ps

module sos_queue import sos_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output item_t rd_item,
  output logic  empty,
  output logic  full
);

  localparam int AW = $clog2(QDEPTH);

  item_t       mem [QDEPTH];
  item_t       rd_item_r;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (AW+1)'(QDEPTH));
  assign rd_item = rd_item_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // The head register is loaded from the entry that becomes the head at this
  // edge; an item written into that very entry is passed straight through.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
    rd_item_r <= (push && (wr_ptr_r == rd_ptr_nxt)) ? wr_item : mem[rd_ptr_nxt];
  end

endmodule

### hdl/sos_back.sv
// Back end: walks the strip slots of the queue head pixel and, while the output
// register is free or popped, loads one vertex per cycle into it. Uses sos_pkg.
`timescale 1ns / 1ps

module sos_back import sos_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [16:0] out_vertex_index,
  output logic        out_last_of_pixel
);

  logic [1:0]  slot_r, slot_nxt;
  logic        act_r, act_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [16:0] out_vtx_r;
  logic        out_last_r;

  logic [1:0]  cur_slot;
  logic [1:0]  last_slot;
  logic        is_last;
  logic        fire;
  logic [8:0]  vi;
  logic [8:0]  vj;

  // Slot 0 is only visited when the pixel needs a leading vertex, slot 3 only
  // when it needs a trailing one.
  assign cur_slot  = act_r ? slot_r : (q_item.pre ? 2'd0 : 2'd1);
  assign last_slot = q_item.post ? 2'd3 : 2'd2;
  assign is_last   = (cur_slot == last_slot);
  assign fire      = !q_empty && (!out_vld_r || out_pop);
  assign q_pop     = fire && is_last;

  assign vi = {1'b0, q_item.i} + 9'(CORNER_DI[q_item.dir][cur_slot]);
  assign vj = {1'b0, q_item.j} + 9'(CORNER_DJ[q_item.dir][cur_slot]);

  always_comb begin
    slot_nxt    = slot_r;
    act_nxt     = act_r;
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
      if (is_last) begin
        act_nxt = 1'b0;
      end else begin
        act_nxt  = 1'b1;
        slot_nxt = cur_slot + 2'd1;
      end
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      act_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      slot_r    <= slot_nxt;
      act_r     <= act_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_vtx_r  <= sos_vertex_number(vi, vj);
      out_last_r <= is_last;
    end
  end

  assign out_empty         = !out_vld_r;
  assign out_vertex_index  = out_vtx_r;
  assign out_last_of_pixel = out_last_r;

endmodule

### hdl/shell_order_strip_index_gen.sv
// Top level of the shell-order strip index generator: front, queue and back.
// Depends on sos_pkg, sos_front, sos_queue and sos_back.
//
//   channel  | handshake        | payload
//   ---------+------------------+-----------------------------------------
//   input    | in_push, in_full | in_pixel_index[15:0]
//   result   | out_pop, out_empty | out_vertex_index[16:0], out_last_of_pixel
//
// Each pixel gives two to four items on the result channel, one per cycle while
// out_pop keeps the output register free; the output register is the limit.
// An input item can be taken every cycle until the front and queue hold QDEPTH pixels.
// The first result of a pixel passes through eight root stages (the first loads at
// the edge that accepts it), the queue head register and the output register.
// Reset is synchronous and active low; it empties the pipeline, the queue and the output.
// A stall on the result side backs up into the queue and then raises in_full.
`timescale 1ns / 1ps

module shell_order_strip_index_gen import sos_pkg::*; #(
  parameter int MAX_DIM = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_pixel_index,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [16:0] out_vertex_index,
  output logic        out_last_of_pixel
);

  // Between the front and the queue: classified pixels, one per cycle at most.
  logic  q_push;
  item_t q_wr_item;

  // Between the queue and the back.
  logic  q_pop;
  logic  q_empty;
  logic  q_full;
  item_t q_rd_item;

  // The front computes the shell of each pixel in an eight-stage square-root
  // pipeline and drops pixels outside the MAX_DIM by MAX_DIM grid at the door.
  // It returns a credit whenever the back retires a pixel from the queue.
  sos_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_pixel_index (in_pixel_index),
    .in_full        (in_full),
    .release_i      (q_pop),
    .q_push         (q_push),
    .q_item         (q_wr_item)
  );

  // The queue decouples the root pipeline from the per-vertex sequencing.
  sos_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty),
    .full    (q_full)
  );

  // The back turns the head pixel into its strip vertices, one per cycle unless stalled.
  sos_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_item            (q_rd_item),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_vertex_index  (out_vertex_index),
    .out_last_of_pixel (out_last_of_pixel)
  );

  // The credit scheme must keep the queue from ever overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full && !q_pop))
    else $error("queue written while full");

  // The back only retires a pixel that is actually in the queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  // A reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending after reset");

endmodule
